// ----- rtl/icmp_echo_reply_rewriter_macros.svh -----
// ============================================================================
// icmp_echo_reply_rewriter_macros.svh
// Assertion macros for the echo reply rewriter; empty when SYNTHESIS is set.
// ============================================================================
`ifndef ICMP_ECHO_REPLY_REWRITER_MACROS_SVH
`define ICMP_ECHO_REPLY_REWRITER_MACROS_SVH
`ifndef SYNTHESIS
`define ICMPR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ICMPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ICMPR_ASSERT(lbl, clk, rst_n, prop, msg)
`define ICMPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/icmpr_pkg.sv -----
// ============================================================================
// icmpr_pkg
// Types, protocol constants and header word positions for the echo rewriter.
// ============================================================================
`default_nettype none

package icmpr_pkg;

    typedef logic [2:0]  t_status;
    typedef logic [2:0]  t_nbytes;
    typedef logic [3:0]  t_ihl;
    typedef logic [15:0] t_half;

    localparam t_status STAT_REPLY     = 3'd0;
    localparam t_status STAT_SHORT     = 3'd1;
    localparam t_status STAT_NOT_IPV4  = 3'd2;
    localparam t_status STAT_NOT_ICMP  = 3'd3;
    localparam t_status STAT_TRUNC     = 3'd4;

    localparam t_nbytes BYTES_NONE = 3'd0;
    localparam t_nbytes BYTES_FULL = 3'd4;

    localparam t_half      ETHERTYPE_IPV4  = 16'h0800;
    localparam logic [7:0] PROTO_ICMP      = 8'd1;
    localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;
    localparam t_ihl       IHL_MIN         = 4'd5;

    // byte counts
    localparam int unsigned IP_HDR_BASE = 14;
    localparam int unsigned MIN_FRAME   = 34;
    localparam int unsigned MIN_REPLY   = 35;

    // word positions in the frame
    localparam int unsigned W_MAC0   = 0;
    localparam int unsigned W_MAC1   = 1;
    localparam int unsigned W_MAC2   = 2;
    localparam int unsigned W_IHL    = 3;
    localparam int unsigned W_PROTO  = 5;
    localparam int unsigned W_CSUM   = 6;
    localparam int unsigned W_IPADDR = 7;
    localparam int unsigned W_ICMP   = 8;

    // two frame bytes in lanes 0/1 as a network order 16-bit value
    function automatic t_half swap16(input t_half lanes);
        return {lanes[7:0], lanes[15:8]};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/icmp_echo_reply_rewriter.sv -----
// ============================================================================
// icmp_echo_reply_rewriter
// Turns an ICMP echo request frame into an echo reply: MAC and IP addresses
// swapped, IP header checksum rebuilt, ICMP type cleared. Other frames drop
// with one status beat at their end.
//
//   Channel  Dir   Handshake                  Payload
//   in       sink  i_in_valid / o_in_ready    i_in_word, i_in_bytes, i_in_last
//   out      src   o_out_valid / i_out_ready  o_out_word, o_out_bytes,
//                                             o_out_last, o_frame_status
//
// Header beats are written to the header RAM at one per cycle while o_in_ready
// is high. Replay reads each buffered beat from the RAM, then loads it into the
// output register; input is held off during replay. Later beats of a reply pass
// at one per cycle through the output register while it is not stalled.
// Reset is synchronous; the header RAM is not cleared.
// Output backpressure stalls input through o_in_ready.
// ============================================================================
`default_nettype none
`include "icmp_echo_reply_rewriter_macros.svh"

module icmp_echo_reply_rewriter #(
    parameter int HEADER_WORDS = 19
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [31:0]           i_in_word,
    input  icmpr_pkg::t_nbytes    i_in_bytes,
    input  logic                  i_in_last,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [31:0]           o_out_word,
    output icmpr_pkg::t_nbytes    o_out_bytes,
    output logic                  o_out_last,
    output icmpr_pkg::t_status    o_frame_status
);
    import icmpr_pkg::*;

    localparam int   POS_W   = $clog2(HEADER_WORDS + 1);
    localparam int   ADDR_W  = $clog2(HEADER_WORDS);
    localparam int   TOT_W   = POS_W + 3;
    localparam t_ihl IHL_MAX = t_ihl'(HEADER_WORDS - 4);

    localparam logic [1:0] ST_BUF  = 2'd0;
    localparam logic [1:0] ST_EMIT = 2'd1;
    localparam logic [1:0] ST_PASS = 2'd2;

    logic [31:0]       r_hdr_mem [HEADER_WORDS];

    logic [1:0]        r_state, n_state;
    logic [POS_W-1:0]  r_pos, n_pos;
    t_ihl              r_ihl, n_ihl;
    logic              r_etype_ok, n_etype_ok;
    logic              r_proto_ok, n_proto_ok;
    t_status           r_drop, n_drop;
    logic [POS_W-1:0]  r_emit_cnt, n_emit_cnt;
    logic [POS_W-1:0]  r_emit_idx, n_emit_idx;
    t_nbytes           r_fin_bytes, n_fin_bytes;
    logic              r_fin_last, n_fin_last;
    logic              r_rd_pend, n_rd_pend;
    logic [POS_W-1:0]  r_rd_idx, n_rd_idx;
    logic [31:0]       r_rd_a;
    logic [31:0]       r_rd_b;
    logic              r_out_valid, n_out_valid;
    logic [31:0]       r_out_word, n_out_word;
    t_nbytes           r_out_bytes, n_out_bytes;
    logic              r_out_last, n_out_last;
    t_status           r_out_status, n_out_status;

    logic              in_acc;
    logic              out_free;
    t_nbytes           in_nb;
    t_ihl              ihl_raw;
    t_ihl              ihl_clamped;
    t_ihl              ihl_cur;
    logic              at_ihl;
    logic              etype_ok_cur;
    logic              proto_ok_cur;
    logic [POS_W-1:0]  pos_nx;
    logic              complete;
    logic [TOT_W-1:0]  total;
    logic [TOT_W-1:0]  need_ip;
    logic [TOT_W-1:0]  need;
    t_status           hdr_reason;
    t_status           end_reason;
    logic              emit_go;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic [31:0]       reply_word;
    logic              rd_final;
    logic              new_frame;
    logic              csum_en;
    t_half             csum;

    icmpr_csum #(
        .IDX_W (POS_W)
    ) u_csum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (new_frame),
        .i_en    (csum_en),
        .i_idx   (r_pos),
        .i_ihl   (ihl_cur),
        .i_word  (i_in_word),
        .o_sum   (csum)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = ((r_state == ST_BUF) || (r_state == ST_PASS)) && out_free;
    assign in_acc     = i_in_valid && o_in_ready;

    // header field decode
    always_comb begin
        in_nb = BYTES_FULL;
        if (i_in_last && i_in_bytes >= 3'd1 && i_in_bytes <= BYTES_FULL) begin
            in_nb = i_in_bytes;
        end
        ihl_raw     = i_in_word[19:16];
        ihl_clamped = ihl_raw;
        if (ihl_raw < IHL_MIN) begin
            ihl_clamped = IHL_MIN;
        end else if (ihl_raw > IHL_MAX) begin
            ihl_clamped = IHL_MAX;
        end
        at_ihl       = (r_pos == POS_W'(W_IHL));
        ihl_cur      = at_ihl ? ihl_clamped : r_ihl;
        etype_ok_cur = at_ihl ? (swap16(i_in_word[15:0]) == ETHERTYPE_IPV4) : r_etype_ok;
        proto_ok_cur = (r_pos == POS_W'(W_PROTO)) ? (i_in_word[31:24] == PROTO_ICMP)
                                                  : r_proto_ok;
        pos_nx   = r_pos + POS_W'(1);
        complete = (r_pos >= POS_W'(W_IHL)) &&
                   (TOT_W'(pos_nx) == TOT_W'(ihl_cur) + TOT_W'(4));
        total    = TOT_W'({r_pos, 2'b00}) + TOT_W'(in_nb);
        need_ip  = TOT_W'({ihl_cur, 2'b00}) + TOT_W'(IP_HDR_BASE);
        need     = (need_ip < TOT_W'(MIN_REPLY)) ? TOT_W'(MIN_REPLY) : need_ip;

        if (!etype_ok_cur) begin
            hdr_reason = STAT_NOT_IPV4;
        end else if (!proto_ok_cur) begin
            hdr_reason = STAT_NOT_ICMP;
        end else begin
            hdr_reason = STAT_REPLY;
        end
        if (total < TOT_W'(MIN_FRAME)) begin
            end_reason = STAT_SHORT;
        end else if (hdr_reason == STAT_REPLY) begin
            end_reason = STAT_TRUNC;
        end else begin
            end_reason = hdr_reason;
        end
    end

    // header replay: read addresses and rewrite
    always_comb begin
        emit_go = (r_state == ST_EMIT) && (r_emit_idx != r_emit_cnt) && !r_rd_pend &&
                  out_free;
        addr_a = r_emit_idx[ADDR_W-1:0];
        addr_b = r_emit_idx[ADDR_W-1:0];
        case (r_emit_idx)
            POS_W'(W_MAC0): begin
                addr_a = ADDR_W'(W_MAC1);
                addr_b = ADDR_W'(W_MAC2);
            end
            POS_W'(W_MAC1): begin
                addr_a = ADDR_W'(W_MAC2);
                addr_b = ADDR_W'(W_MAC0);
            end
            POS_W'(W_MAC2): begin
                addr_a = ADDR_W'(W_MAC0);
                addr_b = ADDR_W'(W_MAC1);
            end
            POS_W'(W_CSUM): begin
                addr_a = ADDR_W'(W_IPADDR);
            end
            POS_W'(W_IPADDR): begin
                addr_a = ADDR_W'(W_ICMP);
                addr_b = ADDR_W'(W_CSUM);
            end
            POS_W'(W_ICMP): begin
                addr_a = ADDR_W'(W_IPADDR);
                addr_b = ADDR_W'(W_ICMP);
            end
            default: begin
            end
        endcase

        case (r_rd_idx)
            POS_W'(W_MAC0), POS_W'(W_MAC1), POS_W'(W_MAC2): begin
                reply_word = {r_rd_b[15:0], r_rd_a[31:16]};
            end
            POS_W'(W_CSUM): begin
                reply_word = {r_rd_a[31:16], swap16(~csum)};
            end
            POS_W'(W_IPADDR): begin
                reply_word = {r_rd_b[31:16], r_rd_a[15:0]};
            end
            POS_W'(W_ICMP): begin
                reply_word = {r_rd_b[31:24], ICMP_ECHO_REPLY, r_rd_a[15:0]};
            end
            default: begin
                reply_word = r_rd_a;
            end
        endcase
        rd_final = (r_rd_idx == r_emit_cnt - POS_W'(1));
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_ihl        = r_ihl;
        n_etype_ok   = r_etype_ok;
        n_proto_ok   = r_proto_ok;
        n_drop       = r_drop;
        n_emit_cnt   = r_emit_cnt;
        n_emit_idx   = r_emit_idx;
        n_fin_bytes  = r_fin_bytes;
        n_fin_last   = r_fin_last;
        n_rd_pend    = r_rd_pend;
        n_rd_idx     = r_rd_idx;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_word   = r_out_word;
        n_out_bytes  = r_out_bytes;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;
        new_frame    = 1'b0;
        csum_en      = 1'b0;

        case (r_state)
            ST_BUF: begin
                if (in_acc) begin
                    csum_en    = 1'b1;
                    n_pos      = pos_nx;
                    n_ihl      = ihl_cur;
                    n_etype_ok = etype_ok_cur;
                    n_proto_ok = proto_ok_cur;
                    if (i_in_last && (!complete || total < need)) begin
                        n_out_valid  = 1'b1;
                        n_out_word   = '0;
                        n_out_bytes  = BYTES_NONE;
                        n_out_last   = 1'b1;
                        n_out_status = end_reason;
                        new_frame    = 1'b1;
                    end else if (complete) begin
                        if (hdr_reason != STAT_REPLY) begin
                            if (i_in_last) begin
                                n_out_valid  = 1'b1;
                                n_out_word   = '0;
                                n_out_bytes  = BYTES_NONE;
                                n_out_last   = 1'b1;
                                n_out_status = hdr_reason;
                                new_frame    = 1'b1;
                            end else begin
                                n_drop  = hdr_reason;
                                n_state = ST_PASS;
                            end
                        end else begin
                            n_state     = ST_EMIT;
                            n_emit_cnt  = pos_nx;
                            n_emit_idx  = '0;
                            n_fin_bytes = in_nb;
                            n_fin_last  = i_in_last;
                        end
                    end
                end
            end
            ST_PASS: begin
                if (in_acc) begin
                    if (r_drop != STAT_REPLY) begin
                        if (i_in_last) begin
                            n_out_valid  = 1'b1;
                            n_out_word   = '0;
                            n_out_bytes  = BYTES_NONE;
                            n_out_last   = 1'b1;
                            n_out_status = r_drop;
                            new_frame    = 1'b1;
                        end
                    end else begin
                        n_out_valid  = 1'b1;
                        n_out_word   = i_in_word;
                        n_out_bytes  = in_nb;
                        n_out_last   = i_in_last;
                        n_out_status = STAT_REPLY;
                        new_frame    = i_in_last;
                    end
                end
            end
            ST_EMIT: begin
                if (emit_go) begin
                    n_rd_pend  = 1'b1;
                    n_rd_idx   = r_emit_idx;
                    n_emit_idx = r_emit_idx + POS_W'(1);
                end
                if (r_rd_pend) begin
                    n_rd_pend    = 1'b0;
                    n_out_valid  = 1'b1;
                    n_out_word   = reply_word;
                    n_out_bytes  = rd_final ? r_fin_bytes : BYTES_FULL;
                    n_out_last   = rd_final && r_fin_last;
                    n_out_status = STAT_REPLY;
                    if (rd_final) begin
                        if (r_fin_last) begin
                            new_frame = 1'b1;
                        end else begin
                            n_state = ST_PASS;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_BUF;
            end
        endcase

        if (new_frame) begin
            n_state = ST_BUF;
            n_pos   = '0;
            n_drop  = STAT_REPLY;
        end
    end

    // header RAM: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_BUF) && in_acc) begin
            r_hdr_mem[r_pos[ADDR_W-1:0]] <= i_in_word;
        end
        if (emit_go) begin
            r_rd_a <= r_hdr_mem[addr_a];
            r_rd_b <= r_hdr_mem[addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_BUF;
            r_pos       <= '0;
            r_ihl       <= '0;
            r_etype_ok  <= 1'b0;
            r_proto_ok  <= 1'b0;
            r_drop      <= STAT_REPLY;
            r_emit_cnt  <= '0;
            r_emit_idx  <= '0;
            r_fin_bytes <= BYTES_FULL;
            r_fin_last  <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_ihl       <= n_ihl;
            r_etype_ok  <= n_etype_ok;
            r_proto_ok  <= n_proto_ok;
            r_drop      <= n_drop;
            r_emit_cnt  <= n_emit_cnt;
            r_emit_idx  <= n_emit_idx;
            r_fin_bytes <= n_fin_bytes;
            r_fin_last  <= n_fin_last;
            r_rd_pend   <= n_rd_pend;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word   <= n_out_word;
        r_out_bytes  <= n_out_bytes;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_word     = r_out_word;
    assign o_out_bytes    = r_out_bytes;
    assign o_out_last     = r_out_last;
    assign o_frame_status = r_out_status;

    `ICMPR_ASSERT(a_rd_slot_free, i_clk, i_rst_n, r_rd_pend |-> !r_out_valid, "RAM data lands on a full output register")
    `ICMPR_ASSERT_NEXT(a_rd_lands, i_clk, i_rst_n, r_rd_pend, o_out_valid, "RAM read did not reach the output")
    `ICMPR_ASSERT(a_status_beat, i_clk, i_rst_n, (o_out_valid && (o_frame_status != STAT_REPLY)) |-> (o_out_last && (o_out_bytes == BYTES_NONE)), "drop status beat is not a final empty beat")
    `ICMPR_ASSERT(a_pos_bound, i_clk, i_rst_n, (r_state == ST_BUF) |-> (r_pos < POS_W'(HEADER_WORDS)), "header position past the buffer")
    `ICMPR_ASSERT(a_emit_bound, i_clk, i_rst_n, (r_state == ST_EMIT) |-> (r_emit_idx <= r_emit_cnt), "replay index past the buffered count")

endmodule

`default_nettype wire

// ----- rtl/icmpr_csum.sv -----
// ============================================================================
// icmpr_csum
// IP header ones-complement sum, built one header beat at a time.
// ============================================================================
`default_nettype none

module icmpr_csum #(
    parameter int IDX_W = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clr,
    input  logic                 i_en,
    input  logic [IDX_W-1:0]     i_idx,
    input  icmpr_pkg::t_ihl      i_ihl,
    input  logic [31:0]          i_word,
    output icmpr_pkg::t_half     o_sum
);
    import icmpr_pkg::*;

    logic [15:0] r_acc;
    logic [15:0] n_acc;
    logic [4:0]  idx;
    logic [4:0]  lo_end;
    logic [4:0]  hi_end;
    logic        add_hi;
    logic        add_lo;
    t_half       hi;
    t_half       lo;
    logic [17:0] sum;
    logic [16:0] f1;
    logic [15:0] f2;

    always_comb begin
        idx    = 5'(i_idx);
        lo_end = 5'(i_ihl) + 5'(W_IHL);
        hi_end = lo_end - 5'd1;
        add_hi = (idx == 5'(W_IHL)) || (idx > 5'(W_IHL) && idx <= hi_end);
        // checksum field itself counts as zero
        add_lo = (idx > 5'(W_IHL)) && (idx <= lo_end) && (idx != 5'(W_CSUM));
        hi     = add_hi ? swap16(i_word[31:16]) : '0;
        lo     = add_lo ? swap16(i_word[15:0]) : '0;
        sum    = 18'(r_acc) + 18'(hi) + 18'(lo);
        f1     = 17'(sum[15:0]) + 17'(sum[17:16]);
        f2     = f1[15:0] + 16'(f1[16]);
        n_acc  = r_acc;
        if (i_clr) begin
            n_acc = '0;
        end else if (i_en) begin
            n_acc = f2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    assign o_sum = r_acc;

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// ============================================================================
// testbench
// Echo reply rewriter check: a short table of directed frames, then random
// frames (echo requests, bad ethertype, bad protocol, truncated, short,
// noise) with bursty input and a stalling output. Every output beat is
// compared field by field with the bench model or a typed row's status.
// ============================================================================
module testbench;

    import icmpr_pkg::*;

    localparam int unsigned HDR_DEPTH  = 19;
    localparam int unsigned IDLE_LIMIT = 4000;
    localparam int unsigned HOLD_LEN   = 400;
    localparam int unsigned RANDOM_BEATS = 80;
    localparam int unsigned DIR_ROWS   = 22;

    typedef struct packed {
        logic [31:0] word;
        t_nbytes     nbytes;
        logic        last;
        t_status     status;
    } t_reply_beat;

    typedef struct packed {
        logic [31:0] word;
        t_nbytes     nbytes;
        logic        last;
        logic        typed;
        t_status     status;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [31:0] i_in_word;
    t_nbytes     i_in_bytes;
    logic        i_in_last;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_out_word;
    t_nbytes     o_out_bytes;
    logic        o_out_last;
    t_status     o_frame_status;

    icmp_echo_reply_rewriter u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_word      (i_in_word),
        .i_in_bytes     (i_in_bytes),
        .i_in_last      (i_in_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_word     (o_out_word),
        .o_out_bytes    (o_out_bytes),
        .o_out_last     (o_out_last),
        .o_frame_status (o_frame_status)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // rewrite model state
    logic [31:0] hdr_mem [HDR_DEPTH];
    int unsigned hdr_pos;
    int unsigned hdr_ihl;
    t_status     drop_code;
    logic        forwarding;

    t_reply_beat reply_beats [$];
    t_reply_beat step_beats [$];
    t_stim_row   dir_rows [DIR_ROWS];

    int unsigned fail_count = 0;
    int unsigned beats_sent = 0;
    int unsigned burst_left = 0;
    logic        hold_req = 1'b0;

    function automatic logic [7:0] hdr_byte(input int unsigned off);
        logic [31:0] w;
        if ((off >> 2) >= HDR_DEPTH) return 8'h00;
        w = hdr_mem[off >> 2];
        return w[8 * (off & 3) +: 8];
    endfunction

    function automatic t_status frame_fault();
        if ({hdr_byte(12), hdr_byte(13)} != ETHERTYPE_IPV4) return STAT_NOT_IPV4;
        if (hdr_byte(23) != PROTO_ICMP) return STAT_NOT_ICMP;
        return STAT_REPLY;
    endfunction

    task automatic clear_frame();
        hdr_pos    = 0;
        hdr_ihl    = 0;
        forwarding = 1'b0;
        drop_code  = STAT_REPLY;
    endtask

    task automatic push_status(input t_status code);
        t_reply_beat rb;
        rb = '{word: 32'h0, nbytes: BYTES_NONE, last: 1'b1, status: code};
        step_beats.push_back(rb);
    endtask

    task automatic build_reply();
        logic [7:0]  b [HDR_DEPTH * 4];
        logic [7:0]  t;
        logic [31:0] sum;
        logic [15:0] csum;
        int unsigned i;
        for (i = 0; i < HDR_DEPTH * 4; i++) b[i] = hdr_byte(i);
        for (i = 0; i < 6; i++) begin
            t = b[i]; b[i] = b[i + 6]; b[i + 6] = t;
        end
        for (i = 26; i < 30; i++) begin
            t = b[i]; b[i] = b[i + 4]; b[i + 4] = t;
        end
        b[24] = 8'h00;
        b[25] = 8'h00;
        sum = 0;
        for (i = IP_HDR_BASE; i + 1 < IP_HDR_BASE + 4 * hdr_ihl && i + 1 < HDR_DEPTH * 4;
             i += 2) begin
            sum = sum + {b[i], b[i + 1]};
            sum = (sum & 32'hFFFF) + (sum >> 16);
        end
        csum  = ~sum[15:0];
        b[24] = csum[15:8];
        b[25] = csum[7:0];
        b[34] = ICMP_ECHO_REPLY;
        for (i = 0; i < HDR_DEPTH; i++)
            hdr_mem[i] = {b[4 * i + 3], b[4 * i + 2], b[4 * i + 1], b[4 * i]};
    endtask

    // one input beat in, the resulting output beats into step_beats
    task automatic rewrite_step(input logic [31:0] w, input t_nbytes nb, input logic last);
        t_nbytes     nv;
        int unsigned ihl, total, need, i;
        logic [7:0]  vb;
        logic        done;
        t_status     code;
        t_reply_beat rb;
        step_beats.delete();
        nv = (nb >= 1 && nb <= 4 && last) ? nb : BYTES_FULL;
        if (forwarding) begin
            if (drop_code != STAT_REPLY) begin
                if (last) begin
                    code = drop_code;
                    clear_frame();
                    push_status(code);
                end
                return;
            end
            rb = '{word: w, nbytes: nv, last: last, status: STAT_REPLY};
            step_beats.push_back(rb);
            if (last) clear_frame();
            return;
        end
        if (hdr_pos < HDR_DEPTH) begin
            hdr_mem[hdr_pos] = w;
            hdr_pos++;
        end
        done = 1'b0;
        if (hdr_pos >= 4) begin
            vb  = hdr_byte(14);
            ihl = vb[3:0];
            if (ihl < IHL_MIN) ihl = IHL_MIN;
            if (ihl > HDR_DEPTH - 4) ihl = HDR_DEPTH - 4;
            hdr_ihl = ihl;
            done = (hdr_pos >= ihl + 4);
        end
        if (last) begin
            total = 4 * (hdr_pos - 1) + nv;
            need  = IP_HDR_BASE + 4 * hdr_ihl;
            if (need < MIN_REPLY) need = MIN_REPLY;
            if (!done || total < need) begin
                code = (total < MIN_FRAME) ? STAT_SHORT : frame_fault();
                if (code == STAT_REPLY) code = STAT_TRUNC;
                clear_frame();
                push_status(code);
                return;
            end
        end
        if (!done) return;
        code = frame_fault();
        if (code != STAT_REPLY) begin
            if (last) begin
                clear_frame();
                push_status(code);
            end else begin
                drop_code  = code;
                forwarding = 1'b1;
            end
            return;
        end
        build_reply();
        for (i = 0; i < hdr_pos; i++) begin
            rb.word   = hdr_mem[i];
            rb.nbytes = (i + 1 == hdr_pos) ? nv : BYTES_FULL;
            rb.last   = (i + 1 == hdr_pos) ? last : 1'b0;
            rb.status = STAT_REPLY;
            step_beats.push_back(rb);
        end
        if (last) clear_frame();
        else forwarding = 1'b1;
    endtask

    // offer one beat, wait for it to be taken, then log what it should produce
    task automatic send_beat(input logic [31:0] w, input t_nbytes nb, input logic last,
                             input logic typed, input t_status code);
        int unsigned gap;
        t_reply_beat rb;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        i_in_bytes <= nb;
        i_in_last  <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        beats_sent++;
        if (beats_sent == 60) hold_req = 1'b1;
        rewrite_step(w, nb, last);
        if (typed) begin
            rb = '{word: 32'h0, nbytes: BYTES_NONE, last: 1'b1, status: code};
            reply_beats.push_back(rb);
        end else begin
            foreach (step_beats[i]) reply_beats.push_back(step_beats[i]);
        end
    endtask

    task automatic send_frame(input logic [7:0] fb [$]);
        int unsigned n, k, j, v;
        logic [31:0] w;
        t_nbytes     nb;
        n = (fb.size() + 3) / 4;
        for (k = 0; k < n; k++) begin
            for (j = 0; j < 4; j++)
                w[8 * j +: 8] = (4 * k + j < fb.size()) ? fb[4 * k + j]
                                                         : 8'($urandom_range(0, 255));
            if (k == n - 1) begin
                nb = t_nbytes'(fb.size() - 4 * k);
                if (nb == BYTES_FULL && $urandom_range(0, 3) == 0) begin
                    v  = $urandom_range(0, 3);
                    nb = (v == 0) ? BYTES_NONE : t_nbytes'(4 + v);
                end
            end else begin
                nb = t_nbytes'($urandom_range(0, 7));
            end
            send_beat(w, nb, k == n - 1, 1'b0, STAT_REPLY);
        end
    endtask

    task automatic random_frame();
        logic [7:0]  fb [$];
        int unsigned kind, r, ihl_f, hdr_len, len, i;
        logic [15:0] et;
        logic [7:0]  pr;
        logic [3:0]  ver, ihl4;
        kind = $urandom_range(0, 99);
        r    = $urandom_range(0, 9);
        ihl_f = (r < 7) ? 5 : (r < 9) ? $urandom_range(6, 15) : $urandom_range(0, 4);
        hdr_len = IP_HDR_BASE + 4 * ((ihl_f < IHL_MIN) ? IHL_MIN : ihl_f);
        if (hdr_len < MIN_REPLY) hdr_len = MIN_REPLY;
        if (kind < 75)
            len = hdr_len + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
        else if (kind < 85)
            len = $urandom_range(MIN_FRAME - 1, hdr_len - 1);
        else if (kind < 93)
            len = $urandom_range(1, MIN_FRAME - 1);
        else
            len = $urandom_range(1, 80);
        for (i = 0; i < len; i++) fb.push_back(8'($urandom_range(0, 255)));
        if (kind < 93) begin
            et = ETHERTYPE_IPV4;
            pr = PROTO_ICMP;
            if (kind >= 55 && kind < 65) begin
                et = 16'($urandom_range(0, 65535));
                if (et == ETHERTYPE_IPV4) et = 16'h86DD;
            end
            if (kind >= 65 && kind < 75) begin
                pr = 8'($urandom_range(0, 255));
                if (pr == PROTO_ICMP) pr = 8'd6;
            end
            ver  = 4'($urandom_range(0, 15));
            ihl4 = 4'(ihl_f);
            if (len > 12) fb[12] = et[15:8];
            if (len > 13) fb[13] = et[7:0];
            if (len > 14) fb[14] = {ver, ihl4};
            if (len > 23) fb[23] = pr;
        end
        send_frame(fb);
    endtask

    // receiver: ready pattern of its own, plus one long hold-off
    initial begin
        int unsigned mode, len, tick;
        logic        hold_done;
        hold_done = 1'b0;
        tick = 0;
        i_out_ready <= 1'b0;
        repeat (3) @(posedge i_clk);
        forever begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(5, 60);
            repeat (len) begin
                if (hold_req && !hold_done) begin
                    i_out_ready <= 1'b0;
                    repeat (HOLD_LEN) @(posedge i_clk);
                    hold_done = 1'b1;
                end
                case (mode)
                    0: begin
                        i_out_ready <= 1'b1;
                    end
                    1: begin
                        i_out_ready <= 1'($urandom_range(0, 1));
                    end
                    default: begin
                        i_out_ready <= (tick % 4 != 0);
                    end
                endcase
                tick++;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_reply_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (reply_beats.size() == 0) begin
                $display("%0t: unexpected beat word=%h bytes=%0d last=%b status=%0d",
                         $time, o_out_word, o_out_bytes, o_out_last, o_frame_status);
                fail_count++;
            end else begin
                want = reply_beats.pop_front();
                if (o_out_word !== want.word) begin
                    $display("%0t: word expected %h actual %h", $time, want.word, o_out_word);
                    fail_count++;
                end
                if (o_out_bytes !== want.nbytes) begin
                    $display("%0t: bytes expected %0d actual %0d",
                             $time, want.nbytes, o_out_bytes);
                    fail_count++;
                end
                if (o_out_last !== want.last) begin
                    $display("%0t: last expected %b actual %b", $time, want.last, o_out_last);
                    fail_count++;
                end
                if (o_frame_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_frame_status);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no beat moving on either side
    initial begin
        int unsigned idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle = 0;
            else idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("[icmp_echo_reply_rewriter] ERROR");
                $finish;
            end
        end
    end

    initial begin
        int unsigned r;
        clear_frame();
        foreach (hdr_mem[i]) hdr_mem[i] = 32'h0;
        // short frames, a full echo request, a frame with a foreign ethertype
        dir_rows = '{
            '{32'h0000_0000, 3'd1, 1'b1, 1'b1, STAT_SHORT},
            '{32'hFFFF_FFFF, 3'd0, 1'b1, 1'b1, STAT_SHORT},
            '{32'h5A5A_A5A5, 3'd5, 1'b1, 1'b1, STAT_SHORT},
            '{32'h3322_1100, 3'd4, 1'b0, 1'b0, STAT_REPLY},
            '{32'h7766_5544, 3'd7, 1'b0, 1'b0, STAT_REPLY},
            '{32'hBBAA_9988, 3'd0, 1'b0, 1'b0, STAT_REPLY},
            '{32'h0045_0008, 3'd2, 1'b0, 1'b0, STAT_REPLY},
            '{32'h3412_1C00, 3'd4, 1'b0, 1'b0, STAT_REPLY},
            '{32'h0140_0040, 3'd4, 1'b0, 1'b0, STAT_REPLY},
            '{32'hA8C0_FFFF, 3'd4, 1'b0, 1'b0, STAT_REPLY},
            '{32'hA8C0_0100, 3'd4, 1'b0, 1'b0, STAT_REPLY},
            '{32'h0008_0200, 3'd4, 1'b0, 1'b0, STAT_REPLY},
            '{32'h0100_CDAB, 3'd7, 1'b1, 1'b0, STAT_REPLY},
            '{32'h3322_1100, 3'd4, 1'b0, 1'b0, STAT_REPLY},
            '{32'h7766_5544, 3'd4, 1'b0, 1'b0, STAT_REPLY},
            '{32'hBBAA_9988, 3'd4, 1'b0, 1'b0, STAT_REPLY},
            '{32'h0045_DD86, 3'd4, 1'b0, 1'b0, STAT_REPLY},
            '{32'h3412_1C00, 3'd4, 1'b0, 1'b0, STAT_REPLY},
            '{32'h0140_0040, 3'd4, 1'b0, 1'b0, STAT_REPLY},
            '{32'hA8C0_FFFF, 3'd4, 1'b0, 1'b0, STAT_REPLY},
            '{32'hA8C0_0100, 3'd4, 1'b0, 1'b0, STAT_REPLY},
            '{32'h0008_0200, 3'd3, 1'b1, 1'b1, STAT_NOT_IPV4}
        };
        i_in_valid <= 1'b0;
        i_in_word  <= 32'h0;
        i_in_bytes <= BYTES_NONE;
        i_in_last  <= 1'b0;
        i_rst_n    <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < DIR_ROWS; r++)
            send_beat(dir_rows[r].word, dir_rows[r].nbytes, dir_rows[r].last,
                      dir_rows[r].typed, dir_rows[r].status);
        while (beats_sent < DIR_ROWS + RANDOM_BEATS) random_frame();
        i_in_valid <= 1'b0;

        while (reply_beats.size() != 0) @(posedge i_clk);
        repeat (2 * HDR_DEPTH + 16) @(posedge i_clk);
        if (fail_count == 0 && reply_beats.size() == 0) begin
            $display("[icmp_echo_reply_rewriter] OK");
        end else begin
            $display("[icmp_echo_reply_rewriter] ERROR");
        end
        $finish;
    end

endmodule
